>>> design/ttsch_pkg.sv
// Package for the tick task scheduler: command and status codes, the command
// item type and default sizes. No dependencies.
package ttsch_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int MAX_FIRE       = 8;
    localparam logic [15:0] WRAP_RESET = 16'd40000;

    // Input modes
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_STOP   = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Result status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_NOT_STARTED = 3'd1;
    localparam t_status ST_NO_TASKS    = 3'd2;
    localparam t_status ST_INVALID     = 3'd3;
    localparam t_status ST_DUPLICATE   = 3'd4;
    localparam t_status ST_SLOT_USED   = 3'd5;
    localparam t_status ST_NOT_FOUND   = 3'd6;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_TICK  = 2'd2,
        OP_BAD   = 2'd3
    } t_op;

    // Classified command passed from the front to the back
    typedef struct packed {
        t_op         op;
        logic [7:0]  id;
        logic [2:0]  slot;
        logic [15:0] period;
        logic        periodic;
    } t_cmd;

endpackage

>>> design/ttsch_front.sv
// Front of the tick task scheduler: accepts input items and classifies them
// into commands. Depends on ttsch_pkg.
module ttsch_front #(
    parameter int SLOT_COUNT = ttsch_pkg::SLOT_COUNT_DEF
) (
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [31:0]       i_s_tdata,
    input  logic [1:0]        i_s_tuser,
    input  logic              i_q_full,
    output logic              o_push,
    output ttsch_pkg::t_cmd   o_cmd
);
    import ttsch_pkg::*;

    logic [7:0] w_id;
    logic [2:0] w_slot;
    logic       w_slot_ok;

    assign w_id      = i_s_tdata[7:0];
    assign w_slot    = i_s_tdata[10:8];
    assign w_slot_ok = 32'(w_slot) < SLOT_COUNT;

    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full;

    // Decode mode and catch bad parameters up front
    always_comb begin
        o_cmd.id       = w_id;
        o_cmd.slot     = w_slot;
        o_cmd.period   = i_s_tdata[26:11];
        o_cmd.periodic = i_s_tdata[27];
        case (i_s_tuser)
            MODE_START: o_cmd.op = (w_id == 8'd0 || !w_slot_ok) ? OP_BAD : OP_START;
            MODE_STOP:  o_cmd.op = (w_id == 8'd0) ? OP_BAD : OP_STOP;
            MODE_TICK:  o_cmd.op = OP_TICK;
            default:    o_cmd.op = OP_BAD;
        endcase
    end

endmodule

>>> design/ttsch_queue.sv
// Two-entry command queue between front and back of the scheduler.
// Depends on ttsch_pkg.
module ttsch_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ttsch_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output ttsch_pkg::t_cmd o_cmd
);
    import ttsch_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

>>> design/ttsch_rem.sv
// Shared remainder unit: restoring division, one quotient bit per cycle.
// No dependencies.
module ttsch_rem (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_busy,
    output logic [15:0] o_rem
);
    logic [15:0] r_dvd;
    logic [15:0] r_dvs;
    logic [16:0] r_rem;
    logic [4:0]  r_cnt;
    logic [16:0] w_shift;

    assign w_shift = {r_rem[15:0], r_dvd[15]};
    assign o_busy  = (r_cnt != 5'd0);
    assign o_rem   = r_rem[15:0];

    // Step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 5'd0;
        end else if (i_start) begin
            r_cnt <= 5'd16;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end

    // Shift and subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= 17'd0;
        end else if (o_busy) begin
            r_dvd <= {r_dvd[14:0], 1'b0};
            if (w_shift >= {1'b0, r_dvs}) begin
                r_rem <= w_shift - {1'b0, r_dvs};
            end else begin
                r_rem <= w_shift;
            end
        end
    end

endmodule

>>> design/ttsch_back.sv
// Back of the tick task scheduler: slot table, slot scans, tick counter and
// result register. Depends on ttsch_pkg and ttsch_rem.
module ttsch_back #(
    parameter int SLOT_COUNT = ttsch_pkg::SLOT_COUNT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [15:0]     i_cfg_wr_data,
    input  logic            i_cmd_valid,
    input  ttsch_pkg::t_cmd i_cmd,
    output logic            o_pop,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [15:0]     o_m_tdata,
    output logic            o_m_tlast,
    output logic            o_m_tuser
);
    import ttsch_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DIV  = 4'b0100,
        S_END  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [7:0]  r_id   [SLOT_COUNT];
    logic [15:0] r_per  [SLOT_COUNT];
    logic        r_perd [SLOT_COUNT];
    logic        r_done [SLOT_COUNT];

    logic [15:0] r_count;
    logic        r_started;
    logic [15:0] r_wrap;
    t_cmd        r_cmd;
    logic [IW-1:0] r_idx;
    logic [3:0]  r_nfire;
    logic        r_any;
    logic        r_dup;
    logic        r_used;
    logic        r_found;
    logic        r_pend_v;
    logic [2:0]  r_pend_slot;
    logic [7:0]  r_pend_id;

    logic        r_ovalid;
    t_status     r_ostatus;
    logic        r_ofired;
    logic [2:0]  r_oslot;
    logic [7:0]  r_oid;
    logic        r_olast;

    logic        w_out_free;
    logic        w_active;
    logic        w_match;
    logic        w_last_idx;
    logic        w_div_start;
    logic        w_div_busy;
    logic [15:0] w_rem;
    logic        w_fire;
    logic        w_report;
    logic        w_div_act;
    logic        w_end_act;
    logic [IW-1:0] w_slot_idx;
    t_status     w_start_st;

    logic        e_valid;
    t_status     e_status;
    logic        e_fired;
    logic [2:0]  e_slot;
    logic [7:0]  e_id;
    logic        e_last;

    assign w_out_free = !r_ovalid || i_m_tready;
    assign w_active   = (r_id[r_idx] != 8'd0) && !r_done[r_idx];
    assign w_match    = (r_id[r_idx] == r_cmd.id);
    assign w_last_idx = (r_idx == LAST_IDX);
    assign w_slot_idx = IW'(r_cmd.slot);
    assign w_fire     = (w_rem == 16'd0);
    assign w_report   = w_fire && (r_nfire < 4'(MAX_FIRE));
    assign w_div_act  = (r_state == S_DIV) && !w_div_busy
                        && !(w_report && r_pend_v && !w_out_free);
    assign w_end_act  = (r_state == S_END) && w_out_free;
    assign w_div_start = (r_state == S_SCAN) && (r_cmd.op == OP_TICK) && w_active
                         && (r_per[r_idx] != 16'd0);
    assign o_pop      = (r_state == S_IDLE) && i_cmd_valid;
    assign w_start_st = r_dup ? ST_DUPLICATE : (r_used ? ST_SLOT_USED : ST_OK);

    ttsch_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_count),
        .i_divisor  (r_per[r_idx]),
        .o_busy     (w_div_busy),
        .o_rem      (w_rem)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == OP_BAD || (i_cmd.op == OP_TICK && !r_started)) begin
                        n_state = S_END;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_div_start) begin
                    n_state = S_DIV;
                end else if ((r_cmd.op == OP_STOP && w_match) || w_last_idx) begin
                    n_state = S_END;
                end
            end
            S_DIV: begin
                if (w_div_act) begin
                    n_state = w_last_idx ? S_END : S_SCAN;
                end
            end
            S_END: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Result to load into the output register
    always_comb begin
        e_valid  = 1'b0;
        e_status = ST_OK;
        e_fired  = 1'b0;
        e_slot   = 3'd0;
        e_id     = 8'd0;
        e_last   = 1'b1;
        if (w_div_act && w_report && r_pend_v) begin
            e_valid = 1'b1;
            e_fired = 1'b1;
            e_slot  = r_pend_slot;
            e_id    = r_pend_id;
            e_last  = 1'b0;
        end else if (w_end_act) begin
            e_valid = 1'b1;
            case (r_cmd.op)
                OP_START: e_status = w_start_st;
                OP_STOP:  e_status = r_found ? ST_OK : ST_NOT_FOUND;
                OP_TICK: begin
                    if (!r_started) begin
                        e_status = ST_NOT_STARTED;
                    end else if (r_pend_v) begin
                        e_fired = 1'b1;
                        e_slot  = r_pend_slot;
                        e_id    = r_pend_id;
                    end else begin
                        e_status = r_any ? ST_OK : ST_NO_TASKS;
                    end
                end
                default: e_status = ST_INVALID;
            endcase
        end
    end

    // Control and slot table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= 16'd0;
            r_started <= 1'b0;
            r_wrap    <= WRAP_RESET;
            r_ovalid  <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_id[i]   <= 8'd0;
                r_per[i]  <= 16'd0;
                r_perd[i] <= 1'b0;
                r_done[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_wrap <= i_cfg_wr_data;
            end
            if (e_valid) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            // take a command
            if (o_pop) begin
                if (i_cmd.op == OP_START) begin
                    r_started <= 1'b1;
                end
                if (i_cmd.op == OP_TICK && r_started) begin
                    r_count <= r_count + 16'd1;
                end
            end
            // stop hit: make the task one-shot and done
            if (r_state == S_SCAN && r_cmd.op == OP_STOP && w_match) begin
                r_perd[r_idx] <= 1'b0;
                r_done[r_idx] <= 1'b1;
            end
            // one-shot task retires once it fires
            if (w_div_act && w_fire && !r_perd[r_idx]) begin
                r_done[r_idx] <= 1'b1;
            end
            if (w_end_act) begin
                if (r_cmd.op == OP_START && !r_dup && !r_used) begin
                    r_id[w_slot_idx]   <= r_cmd.id;
                    r_per[w_slot_idx]  <= r_cmd.period;
                    r_perd[w_slot_idx] <= r_cmd.periodic;
                    r_done[w_slot_idx] <= 1'b0;
                end
                if (r_cmd.op == OP_TICK && r_started && r_count >= r_wrap) begin
                    r_count <= 16'd0;
                end
            end
        end
    end

    // Scan working registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd    <= i_cmd;
            r_idx    <= '0;
            r_nfire  <= 4'd0;
            r_any    <= 1'b0;
            r_dup    <= 1'b0;
            r_used   <= 1'b0;
            r_found  <= 1'b0;
            r_pend_v <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            case (r_cmd.op)
                OP_START: begin
                    if (w_match) begin
                        r_dup <= 1'b1;
                    end
                    if (r_idx == w_slot_idx) begin
                        r_used <= (r_id[r_idx] != 8'd0) && !(!r_perd[r_idx] && r_done[r_idx]);
                    end
                end
                OP_STOP: begin
                    if (w_match) begin
                        r_found <= 1'b1;
                    end
                end
                OP_TICK: begin
                    if (w_active) begin
                        r_any <= 1'b1;
                    end
                end
                default: ;
            endcase
            if (!w_div_start && !w_last_idx) begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (w_div_act) begin
            if (w_report) begin
                r_pend_v    <= 1'b1;
                r_pend_slot <= 3'(r_idx);
                r_pend_id   <= r_id[r_idx];
                r_nfire     <= r_nfire + 4'd1;
            end
            if (!w_last_idx) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (e_valid) begin
            r_ostatus <= e_status;
            r_ofired  <= e_fired;
            r_oslot   <= e_slot;
            r_oid     <= e_id;
            r_olast   <= e_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {2'b00, r_oid, r_oslot, r_ostatus};
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_ofired;

endmodule

>>> design/tick_task_scheduler.sv
// Tick task scheduler. Start, stop and tick items scan the slot table; a tick
// after start runs each active slot with a non-zero period through one shared
// 16-step remainder unit and passes over every other slot without a division.
// Results leave through an output register; a two-entry queue decouples input.
// Reset is synchronous, active low: slots empty, counter 0, wrap_limit 40000.
module tick_task_scheduler #(
    parameter int SLOT_COUNT = ttsch_pkg::SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // task_id[7:0], slot[10:8], period[26:11], periodic[27]
    input  logic [1:0]  i_s_tuser,  // mode[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // status[2:0], fired_slot[5:3], fired_id[13:6]
    output logic        o_m_tlast,  // last
    output logic        o_m_tuser   // fired
);
    import ttsch_pkg::*;

    t_cmd w_fcmd;
    t_cmd w_qcmd;
    logic w_push;
    logic w_full;
    logic w_qvalid;
    logic w_pop;

    ttsch_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_cmd      (w_fcmd)
    );

    ttsch_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_fcmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_cmd   (w_qcmd)
    );

    ttsch_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd_valid   (w_qvalid),
        .i_cmd         (w_qcmd),
        .o_pop         (w_pop),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast),
        .o_m_tuser     (o_m_tuser)
    );

endmodule

>>> design/ttsch_checker.sv
// Port-level checks on the scheduler result stream, bound to the top level.
// Depends on ttsch_pkg and tick_task_scheduler.
module ttsch_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic        o_m_tuser
);
    import ttsch_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result dropped or changed under stall");

    // Reset empties the output register
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // A result without a firing is the only result of its item
    a_nofire_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tlast && o_m_tdata[13:3] == 11'd0)
        else $error("non-firing result malformed");

    // A firing result carries status ok and a non-zero id
    a_fire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[2:0] == ST_OK && o_m_tdata[13:6] != 8'd0)
        else $error("firing result malformed");
endmodule

bind tick_task_scheduler ttsch_checker u_ttsch_checker (.*);

>>> tb/sv/tick_task_scheduler_tb.sv
// Testbench for tick_task_scheduler: drives start, stop, tick and unused-mode items,
// predicts every result in a local scheduler model and checks each one.
// Depends on ttsch_pkg and the tick_task_scheduler RTL.
`timescale 1ns / 100ps

module tick_task_scheduler_tb;
    import ttsch_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEF;

    typedef struct packed {
        t_status    status;
        logic       fired;
        logic [2:0] fired_slot;
        logic [7:0] fired_id;
        logic       last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;   // task_id, slot, period, periodic
    logic [1:0]  i_s_tuser = '0;   // mode
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;        // status, fired_slot, fired_id
    logic        o_m_tlast;        // last
    logic        o_m_tuser;        // fired

    // Scheduler state held by the predictor
    logic [7:0]  task_id_tbl [SLOTS];
    logic [15:0] period_tbl [SLOTS];
    logic        periodic_tbl [SLOTS];
    logic        done_tbl [SLOTS];
    logic [15:0] tick_cnt;
    logic        sched_started;
    logic [15:0] wrap_lim;

    t_result expected_results [$];
    int          error_count = 0;
    bit          calm = 1'b0;   // no idling on either side

    tick_task_scheduler i_dut (.*);

    always #5 i_clk = ~i_clk;

    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic void push_single(input t_status st);
        t_result r;
        r = '{status: st, fired: 1'b0, fired_slot: 3'd0, fired_id: 8'd0, last: 1'b1};
        expected_results.push_back(r);
    endfunction

    // Predict the results of one item and update the scheduler state
    function automatic void predict_schedule(input logic [1:0] mode, input logic [7:0] id,
            input logic [2:0] sl, input logic [15:0] per, input logic perd);
        t_status st;
        t_result r;
        int n;
        bit any_active;
        bit hit;
        n = 0;
        any_active = 0;
        hit = 0;
        st = ST_OK;
        case (mode)
            MODE_START: begin
                if (id == 0) st = ST_INVALID;
                else begin
                    sched_started = 1'b1;
                    for (int i = 0; i < SLOTS; i++) if (task_id_tbl[i] == id) hit = 1;
                    if (hit) st = ST_DUPLICATE;
                    else if (task_id_tbl[sl] != 0 && !(!periodic_tbl[sl] && done_tbl[sl]))
                        st = ST_SLOT_USED;
                    else begin
                        task_id_tbl[sl] = id;
                        period_tbl[sl] = per;
                        periodic_tbl[sl] = perd;
                        done_tbl[sl] = 1'b0;
                    end
                end
                push_single(st);
            end
            MODE_STOP: begin
                if (id == 0) st = ST_INVALID;
                else begin
                    st = ST_NOT_FOUND;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!hit && task_id_tbl[i] == id) begin
                            hit = 1;
                            periodic_tbl[i] = 1'b0;
                            done_tbl[i] = 1'b1;
                            st = ST_OK;
                        end
                    end
                end
                push_single(st);
            end
            MODE_TICK: begin
                if (!sched_started) push_single(ST_NOT_STARTED);
                else begin
                    tick_cnt = tick_cnt + 16'd1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (task_id_tbl[i] != 0 && !done_tbl[i]) begin
                            any_active = 1;
                            if (period_tbl[i] != 0 && tick_cnt % period_tbl[i] == 0) begin
                                if (!periodic_tbl[i]) done_tbl[i] = 1'b1;
                                if (n < MAX_FIRE) begin
                                    r = '{status: ST_OK, fired: 1'b1, fired_slot: 3'(i),
                                          fired_id: task_id_tbl[i], last: 1'b0};
                                    expected_results.push_back(r);
                                    n++;
                                end
                            end
                        end
                    end
                    if (tick_cnt >= wrap_lim) tick_cnt = 16'd0;
                    if (n == 0) push_single(any_active ? ST_OK : ST_NO_TASKS);
                    else expected_results[$].last = 1'b1;
                end
            end
            default: push_single(ST_INVALID);
        endcase
    endfunction

    // Send one item, idling first at random; valid stays up until the next
    // item or an idle cycle replaces it
    task automatic send_item(input logic [1:0] mode, input logic [7:0] id,
            input logic [2:0] sl, input logic [15:0] per, input logic perd);
        while (!calm && $urandom_range(99) < 20) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= mode;
        i_s_tdata <= {4'd0, perd, per, sl, id};
        predict_schedule(mode, id, sl, per, perd);
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Drain outstanding results, then give the block time to finish a silent tail
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_wrap(input logic [15:0] v);
        wait_idle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        wrap_lim = v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Result sink with random stalls
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{status: o_m_tdata[2:0], fired: o_m_tuser, fired_slot: o_m_tdata[5:3],
                    fired_id: o_m_tdata[13:6], last: o_m_tlast};
            if (expected_results.size() == 0) report("result with none expected");
            else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report($sformatf("status %0d want %0d", got.status, want.status));
                if (got.fired !== want.fired)
                    report($sformatf("fired %0b want %0b", got.fired, want.fired));
                if (got.fired_slot !== want.fired_slot)
                    report($sformatf("slot %0d want %0d", got.fired_slot, want.fired_slot));
                if (got.fired_id !== want.fired_id)
                    report($sformatf("id %0d want %0d", got.fired_id, want.fired_id));
                if (got.last !== want.last)
                    report($sformatf("last %0b want %0b", got.last, want.last));
            end
        end
        i_m_tready <= calm || ($urandom_range(99) >= 20);
    end

    task automatic test_before_start();
        send_item(MODE_TICK, 8'd0, 3'd0, 16'd0, 1'b0);
        send_item(MODE_STOP, 8'd9, 3'd0, 16'd0, 1'b0);
        send_item(MODE_STOP, 8'd0, 3'd0, 16'd0, 1'b0);
        send_item(MODE_UNUSED, 8'hFF, 3'd7, 16'hFFFF, 1'b1);
        send_item(MODE_START, 8'd0, 3'd7, 16'd5, 1'b1);
        send_item(MODE_TICK, 8'd0, 3'd0, 16'd0, 1'b0);
    endtask

    task automatic test_start_checks();
        send_item(MODE_START, 8'd1, 3'd0, 16'd1, 1'b1);
        send_item(MODE_TICK, 8'd0, 3'd0, 16'd0, 1'b0);
        send_item(MODE_START, 8'd1, 3'd3, 16'd2, 1'b1);
        send_item(MODE_START, 8'd2, 3'd0, 16'd2, 1'b1);
        send_item(MODE_START, 8'hFF, 3'd7, 16'hFFFF, 1'b0);
        send_item(MODE_START, 8'd3, 3'd5, 16'd0, 1'b1);
        send_item(MODE_START, 8'd4, 3'd6, 16'd3, 1'b0);
        for (int k = 0; k < 4; k++) send_item(MODE_TICK, 8'd0, 3'd0, 16'd0, 1'b0);
        send_item(MODE_START, 8'd4, 3'd2, 16'd1, 1'b1);
        send_item(MODE_START, 8'd5, 3'd6, 16'd1, 1'b1);
        send_item(MODE_STOP, 8'd1, 3'd0, 16'd0, 1'b0);
        send_item(MODE_STOP, 8'd1, 3'd0, 16'd0, 1'b0);
        send_item(MODE_STOP, 8'd77, 3'd0, 16'd0, 1'b0);
        send_item(MODE_START, 8'd1, 3'd1, 16'd1, 1'b1);
        send_item(MODE_TICK, 8'd0, 3'd0, 16'd0, 1'b0);
    endtask

    // Wrap limits at the extremes, with every slot firing on each tick
    task automatic test_wrap_extremes();
        for (int i = 0; i < SLOTS; i++) send_item(MODE_STOP, 8'(i + 1), 3'd0, 16'd0, 1'b0);
        send_item(MODE_STOP, 8'hFF, 3'd0, 16'd0, 1'b0);
        send_item(MODE_STOP, 8'd3, 3'd0, 16'd0, 1'b0);
        send_item(MODE_STOP, 8'd4, 3'd0, 16'd0, 1'b0);
        send_item(MODE_STOP, 8'd5, 3'd0, 16'd0, 1'b0);
        send_item(MODE_TICK, 8'd0, 3'd0, 16'd0, 1'b0);
        write_wrap(16'd1);
        for (int i = 0; i < SLOTS; i++)
            send_item(MODE_START, 8'(i + 100), 3'(i), 16'd1, 1'b1);
        for (int k = 0; k < 3; k++) send_item(MODE_TICK, 8'd0, 3'd0, 16'd0, 1'b0);
        write_wrap(16'hFFFF);
        for (int k = 0; k < 3; k++) send_item(MODE_TICK, 8'd0, 3'd0, 16'd0, 1'b0);
        write_wrap(16'd0);
        send_item(MODE_TICK, 8'd0, 3'd0, 16'd0, 1'b0);
    endtask

    // Random phases: ticks half of the time, over a small id pool, with small periods
    task automatic test_random(input logic [15:0] wrap);
        logic [1:0]  mode;
        logic [15:0] per;
        int          pick;
        write_wrap(wrap);
        for (int k = 0; k < 50; k++) begin
            pick = $urandom_range(99);
            mode = pick < 50 ? MODE_TICK : pick < 75 ? MODE_START :
                   pick < 95 ? MODE_STOP : MODE_UNUSED;
            per = $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(6));
            send_item(mode, $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(12)),
                      3'($urandom), per, 1'($urandom));
        end
    endtask

    initial begin
        wrap_lim = WRAP_RESET;
        tick_cnt = '0;
        sched_started = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            task_id_tbl[i] = '0;
            period_tbl[i] = '0;
            periodic_tbl[i] = 1'b0;
            done_tbl[i] = 1'b0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_before_start();
        test_start_checks();
        test_wrap_extremes();
        test_random(16'd7);
        calm = 1'b1;
        test_random(16'd12);
        calm = 1'b0;
        test_random(WRAP_RESET);
        test_random(16'd5);
        wait_idle();
        if (error_count == 0) $display("tick_task_scheduler_tb: clean");
        else $display("tick_task_scheduler_tb: errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("tick_task_scheduler_tb: errors");
        $finish;
    end

endmodule

>>> filelist.f
design/ttsch_pkg.sv
design/ttsch_front.sv
design/ttsch_queue.sv
design/ttsch_rem.sv
design/ttsch_back.sv
design/tick_task_scheduler.sv
design/ttsch_checker.sv
tb/sv/tick_task_scheduler_tb.sv
